// ===== sv/bef_pkg.sv =====
// ----------------------------------------------------------------------------
// bef_pkg
// shared types, constants and helpers for the band envelope follower
// ----------------------------------------------------------------------------
package bef_pkg;

  localparam int LANES      = 4;
  localparam int BAND_W     = 2;
  localparam int LVL_W      = 16;
  localparam int HOLD_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PROD_W     = 32;

  localparam logic [LVL_W-1:0]  ONE_Q15   = 16'h8000;
  localparam logic [LVL_W-1:0]  EPS_LSB   = 16'd32;
  localparam logic [LVL_W-1:0]  RANGE_MIN = 16'd33;
  localparam logic [LVL_W-1:0]  RATE_MIN  = 16'd328;
  localparam logic [HOLD_W-1:0] HOLD_MAX  = 6'd60;
  localparam logic [PROD_W-1:0] CEIL_ADD  = 32'd32767;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_GAIN,
    ST_SCALE,
    ST_HOLD,
    ST_MOVE,
    ST_APPLY,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [LVL_W-1:0] num;
    logic [LVL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [LVL_W-1:0] sat_one(input logic [LVL_W-1:0] v);
    sat_one = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  function automatic logic [LVL_W-1:0] clamp_rate(input logic [LVL_W-1:0] v);
    if (v < RATE_MIN) begin
      clamp_rate = RATE_MIN;
    end else begin
      clamp_rate = sat_one(v);
    end
  endfunction

endpackage

// ===== sv/bef_div.sv =====
// ----------------------------------------------------------------------------
// bef_div
// restoring divider, one quotient bit a cycle: quot = floor(num * 2^15 / den)
// for num <= den, sixteen steps per division
// ----------------------------------------------------------------------------
module bef_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bef_pkg::div_req_t req,
  output bef_pkg::div_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [3:0]                  cnt_r, cnt_nxt;
  logic [bef_pkg::LVL_W:0]     rem_r, rem_nxt;
  logic [bef_pkg::LVL_W-1:0]   den_r, den_nxt;
  logic [bef_pkg::LVL_W-1:0]   quot_r, quot_nxt;
  logic                        ge;
  logic [bef_pkg::LVL_W:0]     rem_sub;

  always_comb begin
    ge       = (rem_r >= {1'b0, den_r});
    rem_sub  = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd15;
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
      quot_nxt = '0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[bef_pkg::LVL_W-2:0], ge};
      rem_nxt  = {rem_sub[bef_pkg::LVL_W-1:0], 1'b0};
      cnt_nxt  = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== sv/band_envelope_follower.sv =====
// ----------------------------------------------------------------------------
// band_envelope_follower
// four-band attack/release envelope follower with hold, one word per frame
//
// Each input word carries four band levels; the block walks the bands one
// after another and returns one word of four activations and a live flag.
// A disabled band goes from setup straight to the next band. An enabled
// band that needs no division (level at or below its threshold, or a narrow
// threshold range) passes setup, hold, move and apply; one above threshold
// also waits on the 16-step shared divider and passes gain and scale before
// hold. The other arithmetic goes through one shared 16x16 multiplier.
// in_tready is low from acceptance to the result word, so no word is taken
// mid-frame. The result sits in an output register, so the next word is
// taken while the previous result waits; a frame that finishes while that
// result is still waiting holds until it is taken.
// ----------------------------------------------------------------------------
module band_envelope_follower #(
  parameter int NUM_BANDS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // level_band0, level_band1, level_band2, level_band3
  input  logic [63:0]                      in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // activation_band0..3, band_live, zero padding
  output logic [71:0]                      out_tdata,
  input  logic                             cfg_we,
  input  logic [bef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bef_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int LW = bef_pkg::LVL_W;
  localparam int HW = bef_pkg::HOLD_W;

  bef_pkg::state_t state_r, state_nxt;

  logic [63:0] thr_reg_r, gain_reg_r, att_reg_r, rel_reg_r;
  logic [23:0] hold_reg_r;
  logic [3:0]  en_reg_r;

  logic [LW-1:0] lvl_r   [bef_pkg::LANES];
  logic [LW-1:0] env_r   [bef_pkg::LANES];
  logic [HW-1:0] hold_r  [bef_pkg::LANES];

  logic [bef_pkg::BAND_W-1:0] band_r, band_nxt;
  logic                       any_r, any_nxt;
  logic [LW-1:0]              q_r, q_nxt;
  logic [LW-1:0]              tgt_r, tgt_nxt;
  logic                       rise_r, rise_nxt;
  logic [bef_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [71:0]                out_tdata_r, out_tdata_nxt;

  logic                       env_we, hold_we;
  logic [LW-1:0]              env_wdata;
  logic [HW-1:0]              hold_wdata;

  logic          band_en;
  logic [LW-1:0] lvl_sat, thr_sat, gain_sat, att_c, rel_c, env_cur;
  logic [HW-1:0] hlen, hold_cur;
  logic [LW:0]   range_w;
  logic          go_div;
  logic [LW-1:0] mul_a, mul_b, diff;
  logic          rise;
  logic [17:0]   scaled;
  logic [LW-1:0] env_new;
  logic [bef_pkg::PROD_W-1:0] dec_sum;
  logic          out_free;

  bef_pkg::div_req_t div_req;
  bef_pkg::div_rsp_t div_rsp;

  bef_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_reg_r  <= 64'h2666266626662666;
      gain_reg_r <= 64'h4000400040004000;
      att_reg_r  <= 64'h5333533353335333;
      rel_reg_r  <= 64'h170A170A170A170A;
      hold_reg_r <= 24'h186186;
      en_reg_r   <= 4'h0;
    end else if (cfg_we) begin
      case (cfg_index)
        bef_pkg::REG_THRESHOLDS: thr_reg_r  <= cfg_wdata;
        bef_pkg::REG_GAINS:      gain_reg_r <= cfg_wdata;
        bef_pkg::REG_ATTACK:     att_reg_r  <= cfg_wdata;
        bef_pkg::REG_RELEASE:    rel_reg_r  <= cfg_wdata;
        bef_pkg::REG_HOLD:       hold_reg_r <= cfg_wdata[23:0];
        bef_pkg::REG_ENABLE:     en_reg_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // per-band operand selection
  always_comb begin
    band_en  = (int'(band_r) < NUM_BANDS) && en_reg_r[band_r];
    lvl_sat  = bef_pkg::sat_one(lvl_r[band_r]);
    thr_sat  = bef_pkg::sat_one(thr_reg_r[16*band_r +: 16]);
    gain_sat = bef_pkg::sat_one(gain_reg_r[16*band_r +: 16]);
    att_c    = bef_pkg::clamp_rate(att_reg_r[16*band_r +: 16]);
    rel_c    = bef_pkg::clamp_rate(rel_reg_r[16*band_r +: 16]);
    hlen     = hold_reg_r[6*band_r +: 6];
    if (hlen > bef_pkg::HOLD_MAX) begin
      hlen = bef_pkg::HOLD_MAX;
    end
    env_cur  = env_r[band_r];
    hold_cur = hold_r[band_r];
    range_w  = {1'b0, bef_pkg::ONE_Q15} - {1'b0, thr_sat};
    go_div   = (lvl_sat > thr_sat) && (range_w[LW-1:0] > bef_pkg::RANGE_MIN);
    rise     = (tgt_r > env_cur);
    diff     = rise ? (tgt_r - env_cur) : (env_cur - tgt_r);
    scaled   = prod_r[31:14];
    dec_sum  = prod_r + bef_pkg::CEIL_ADD;
    out_free = !out_tvalid_r || out_tready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bef_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = bef_pkg::ST_SETUP;
      end
      bef_pkg::ST_SETUP: begin
        if (!band_en) begin
          state_nxt = bef_pkg::ST_NEXT;
        end else if (go_div) begin
          state_nxt = bef_pkg::ST_DIV;
        end else begin
          state_nxt = bef_pkg::ST_HOLD;
        end
      end
      bef_pkg::ST_DIV: begin
        if (div_rsp.done) state_nxt = bef_pkg::ST_GAIN;
      end
      bef_pkg::ST_GAIN:  state_nxt = bef_pkg::ST_SCALE;
      bef_pkg::ST_SCALE: state_nxt = bef_pkg::ST_HOLD;
      bef_pkg::ST_HOLD:  state_nxt = bef_pkg::ST_MOVE;
      bef_pkg::ST_MOVE:  state_nxt = bef_pkg::ST_APPLY;
      bef_pkg::ST_APPLY: state_nxt = bef_pkg::ST_NEXT;
      bef_pkg::ST_NEXT: begin
        if (band_r == bef_pkg::BAND_W'(bef_pkg::LANES - 1)) begin
          state_nxt = bef_pkg::ST_DONE;
        end else begin
          state_nxt = bef_pkg::ST_SETUP;
        end
      end
      bef_pkg::ST_DONE: begin
        if (out_free) state_nxt = bef_pkg::ST_IDLE;
      end
      default: state_nxt = bef_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    band_nxt       = band_r;
    any_nxt        = any_r;
    q_nxt          = q_r;
    tgt_nxt        = tgt_r;
    rise_nxt       = rise_r;
    prod_nxt       = prod_r;
    env_we         = 1'b0;
    hold_we        = 1'b0;
    env_wdata      = '0;
    hold_wdata     = '0;
    env_new        = '0;
    mul_a          = q_r;
    mul_b          = gain_sat;
    div_req.start  = 1'b0;
    div_req.num    = lvl_sat - thr_sat;
    div_req.den    = range_w[LW-1:0];
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    in_tready      = 1'b0;
    case (state_r)
      bef_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        band_nxt  = '0;
        any_nxt   = 1'b0;
      end
      bef_pkg::ST_SETUP: begin
        tgt_nxt = '0;
        if (!band_en) begin
          env_we  = 1'b1;
          hold_we = 1'b1;
        end else if (go_div) begin
          div_req.start = 1'b1;
        end
      end
      bef_pkg::ST_DIV: begin
        if (div_rsp.done) q_nxt = div_rsp.quot;
      end
      bef_pkg::ST_GAIN: begin
        prod_nxt = {16'd0, mul_a} * {16'd0, mul_b};
      end
      bef_pkg::ST_SCALE: begin
        tgt_nxt = (scaled > {2'b00, bef_pkg::ONE_Q15}) ? bef_pkg::ONE_Q15 : scaled[LW-1:0];
      end
      bef_pkg::ST_HOLD: begin
        if (tgt_r > bef_pkg::EPS_LSB) begin
          hold_we    = 1'b1;
          hold_wdata = hlen;
        end else if (hold_cur != '0) begin
          hold_we    = 1'b1;
          hold_wdata = hold_cur - HW'(1);
          tgt_nxt    = env_cur;
        end
      end
      bef_pkg::ST_MOVE: begin
        mul_a    = diff;
        mul_b    = rise ? att_c : rel_c;
        rise_nxt = rise;
        prod_nxt = {16'd0, mul_a} * {16'd0, mul_b};
      end
      bef_pkg::ST_APPLY: begin
        if (rise_r) begin
          env_new = env_cur + prod_r[30:15];
        end else begin
          env_new = env_cur - dec_sum[30:15];
        end
        if (env_new < bef_pkg::RANGE_MIN) env_new = '0;
        env_we    = 1'b1;
        env_wdata = env_new;
        if (env_new > bef_pkg::EPS_LSB) any_nxt = 1'b1;
      end
      bef_pkg::ST_NEXT: begin
        band_nxt = band_r + bef_pkg::BAND_W'(1);
      end
      bef_pkg::ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {7'd0, any_r, env_r[3], env_r[2], env_r[1], env_r[0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bef_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < bef_pkg::LANES; i++) begin
        env_r[i]  <= '0;
        hold_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (env_we) env_r[band_r] <= env_wdata;
      if (hold_we) hold_r[band_r] <= hold_wdata;
    end
    band_r      <= band_nxt;
    any_r       <= any_nxt;
    q_r         <= q_nxt;
    tgt_r       <= tgt_nxt;
    rise_r      <= rise_nxt;
    prod_r      <= prod_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (in_tvalid && in_tready) begin
      for (int i = 0; i < bef_pkg::LANES; i++) begin
        lvl_r[i] <= in_tdata[16*i +: 16];
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== sv/bef_checker.sv =====
// ----------------------------------------------------------------------------
// bef_checker
// port-level checks for the band envelope follower
// ----------------------------------------------------------------------------
module bef_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // in_tready stays low while a frame is worked on, so no second word straight after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed");

  // activations snap to zero at epsilon, so the live flag means some lane nonzero
  a_band_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[64] == (out_tdata[63:0] != 64'd0)))
    else $error("live flag disagrees with activations");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[15:0] <= 16'h8000) && (out_tdata[31:16] <= 16'h8000) &&
                    (out_tdata[47:32] <= 16'h8000) && (out_tdata[63:48] <= 16'h8000) &&
                    (out_tdata[71:65] == 7'd0)))
    else $error("activation above one or padding set");

endmodule

bind band_envelope_follower bef_checker u_bef_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/band_envelope_follower_tb.sv =====
// ----------------------------------------------------------------------------
// band_envelope_follower_tb
// self-checking bench for the four-band attack/release envelope follower
//
// A scoreboard class carries its own copy of the configuration registers and
// of the per-band envelope and hold state, works out the result word for each
// accepted level word and compares the returned words field by field. A short
// directed run covers reset values, the masked and ignored register writes,
// saturated lanes, the narrow threshold range and disabled bands. After that
// come phases with fresh settings (the extremes first), each feeding runs of
// loud and quiet frames per band with some noise, while the sender bursts and
// the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module band_envelope_follower_tb;
  import bef_pkg::*;

  localparam int BANDS           = 4;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 128;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [15:0] CORNERS [10] = '{
    16'd0, 16'd1, 16'd327, 16'd328, 16'd32734,
    16'd32735, 16'd32767, 16'd32768, 16'd32769, 16'hFFFF
  };

  class activation_scoreboard;
    logic [63:0] thr_reg;
    logic [63:0] gain_reg;
    logic [63:0] att_reg;
    logic [63:0] rel_reg;
    logic [23:0] hold_reg;
    logic [3:0]  en_reg;
    logic [15:0] env_st [BANDS];
    logic [5:0]  hold_st [BANDS];
    logic [71:0] expected_q [$];
    int unsigned n_words;
    int unsigned n_checked;
    int unsigned n_active;
    int unsigned n_errors;

    function new();
      thr_reg  = 64'h2666_2666_2666_2666;
      gain_reg = 64'h4000_4000_4000_4000;
      att_reg  = 64'h5333_5333_5333_5333;
      rel_reg  = 64'h170A_170A_170A_170A;
      hold_reg = 24'h18_6186;
      en_reg   = 4'h0;
      for (int b = 0; b < BANDS; b++) begin
        env_st[b]  = '0;
        hold_st[b] = '0;
      end
      n_words   = 0;
      n_checked = 0;
      n_active  = 0;
      n_errors  = 0;
    endfunction

    function bit [31:0] to_one(bit [31:0] v);
      return (v > ONE_Q15) ? 32'(ONE_Q15) : v;
    endfunction

    function bit [31:0] to_rate(bit [31:0] v);
      return (v < RATE_MIN) ? 32'(RATE_MIN) : to_one(v);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_THRESHOLDS: thr_reg = val;
        REG_GAINS:      gain_reg = val;
        REG_ATTACK:     att_reg = val;
        REG_RELEASE:    rel_reg = val;
        REG_HOLD:       hold_reg = val[23:0];
        REG_ENABLE:     en_reg = val[3:0];
        default: ;
      endcase
    endfunction

    function void note_levels(logic [63:0] levels);
      bit [31:0]   lvl;
      bit [31:0]   thr;
      bit [31:0]   gn;
      bit [31:0]   att;
      bit [31:0]   rel;
      bit [31:0]   hlen;
      bit [31:0]   tgt;
      bit [31:0]   q;
      bit [31:0]   env;
      bit          any;
      logic [71:0] word;
      word = '0;
      any  = 1'b0;
      for (int b = 0; b < BANDS; b++) begin
        if (!en_reg[b]) begin
          env_st[b]  = '0;
          hold_st[b] = '0;
        end else begin
          lvl  = to_one(32'(levels[16*b +: 16]));
          thr  = to_one(32'(thr_reg[16*b +: 16]));
          gn   = to_one(32'(gain_reg[16*b +: 16]));
          att  = to_rate(32'(att_reg[16*b +: 16]));
          rel  = to_rate(32'(rel_reg[16*b +: 16]));
          hlen = 32'(hold_reg[6*b +: 6]);
          if (hlen > HOLD_MAX) hlen = 32'(HOLD_MAX);
          // level above threshold rescaled to full range, then gain
          tgt = '0;
          if (lvl > thr && (ONE_Q15 - thr) > RANGE_MIN) begin
            q   = ((lvl - thr) << 15) / (ONE_Q15 - thr);
            tgt = to_one((q * gn) >> 14);
          end
          env = 32'(env_st[b]);
          if (tgt > EPS_LSB) begin
            hold_st[b] = hlen[5:0];
          end else if (hold_st[b] != '0) begin
            hold_st[b] = hold_st[b] - 6'd1;
            tgt = env;
          end
          if (tgt > env) begin
            env = env + (((tgt - env) * att) >> 15);
          end else begin
            env = env - (((env - tgt) * rel + CEIL_ADD) >> 15);
          end
          if (env <= EPS_LSB) env = '0;
          env_st[b] = env[15:0];
          if (env > EPS_LSB) any = 1'b1;
        end
        word[16*b +: 16] = env_st[b];
      end
      word[64] = any;
      expected_q.push_back(word);
      n_words++;
    endfunction

    function void check_word(logic [71:0] got);
      logic [71:0] want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got[64] === 1'b1) n_active++;
      for (int b = 0; b < BANDS; b++) begin
        if (got[16*b +: 16] !== want[16*b +: 16]) begin
          $error("activation_band%0d expected %0d got %0d", b,
                 want[16*b +: 16], got[16*b +: 16]);
          n_errors++;
        end
      end
      if (got[64] !== want[64]) begin
        $error("band_live expected %0d got %0d", want[64], got[64]);
        n_errors++;
      end
      if (got[71:65] !== want[71:65]) begin
        $error("padding expected %0d got %0d", want[71:65], got[71:65]);
        n_errors++;
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [71:0]           out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  activation_scoreboard sb = new();

  int unsigned burst_left = 0;
  bit          steady     = 1'b0;
  bit          loud [BANDS];
  int unsigned run_left [BANDS];
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  band_envelope_follower #(
    .NUM_BANDS (BANDS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= stall_left[3];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  task automatic send_levels(input logic [63:0] levels);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= {$urandom, $urandom};
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= levels;
    do @(posedge clk); while (!in_tready);
    sb.note_levels(levels);
    burst_left--;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] lanes(int unsigned lo, int unsigned hi);
    logic [63:0] v;
    for (int b = 0; b < 4; b++) begin
      v[16*b +: 16] = ($urandom_range(0, 4) == 0) ? CORNERS[$urandom_range(0, 9)]
                                                  : 16'($urandom_range(lo, hi));
    end
    return v;
  endfunction

  task automatic load_settings(input int kind);
    logic [63:0] thr;
    logic [63:0] gn;
    logic [63:0] att;
    logic [63:0] rel;
    logic [63:0] hold;
    logic [63:0] en;
    case (kind)
      0: begin
        thr  = '0;
        gn   = '1;
        att  = '1;
        rel  = '1;
        hold = '1;
        en   = '1;
      end
      1: begin
        thr  = '0;
        gn   = {4{ONE_Q15}};
        att  = '0;
        rel  = '0;
        hold = {$urandom, 8'($urandom), 24'd0};
        en   = {60'd0, 4'hF};
      end
      default: begin
        thr  = lanes(0, 24000);
        gn   = lanes(4096, 32768);
        att  = lanes(328, 32768);
        rel  = lanes(328, 16384);
        hold = {$urandom, $urandom};
        for (int b = 0; b < 4; b++) begin
          hold[6*b +: 6] = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(0, 8));
        end
        en = {$urandom, $urandom};
        if ($urandom_range(0, 2) != 0) en[3:0] = 4'hF;
      end
    endcase
    write_reg(REG_THRESHOLDS, thr);
    write_reg(REG_GAINS, gn);
    write_reg(REG_ATTACK, att);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_HOLD, hold);
    write_reg(REG_ENABLE, en);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_HI, {$urandom, $urandom});
  endtask

  // runs of loud and quiet frames per band, with a little noise
  function automatic logic [63:0] next_levels();
    logic [63:0] v;
    int unsigned thr;
    for (int b = 0; b < BANDS; b++) begin
      if (run_left[b] == 0) begin
        loud[b]     = !loud[b];
        run_left[b] = loud[b] ? $urandom_range(1, 30) : $urandom_range(1, 80);
      end
      run_left[b]--;
      thr = 32'(sb.thr_reg[16*b +: 16]);
      if (thr > 32768) thr = 32768;
      case ($urandom_range(0, 19))
        0: v[16*b +: 16] = 16'($urandom_range(0, 65535));
        1: v[16*b +: 16] = CORNERS[$urandom_range(0, 9)];
        default: v[16*b +: 16] = loud[b] ? 16'($urandom_range(thr, 32768))
                                         : 16'($urandom_range(0, thr));
      endcase
    end
    return v;
  endfunction

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int b = 0; b < BANDS; b++) begin
      loud[b]     = 1'b0;
      run_left[b] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, all bands disabled
    send_levels({4{16'hFFFF}});
    send_levels({4{ONE_Q15}});
    drain();

    // enable written wide, spare indexes ignored
    write_reg(REG_ENABLE, 64'hDEAD_BEEF_0000_00FF);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 64'h0123_4567_89AB_CDEF);
    repeat (3) send_levels({4{ONE_Q15}});
    repeat (8) send_levels('0);
    drain();

    // saturated lanes, clamped rates and hold, narrow threshold range
    write_reg(REG_THRESHOLDS, {16'd32734, 16'd32735, ONE_Q15, 16'd0});
    write_reg(REG_GAINS, {16'd16384, 16'd0, 16'hFFFF, ONE_Q15});
    write_reg(REG_ATTACK, {16'd327, 16'd328, 16'hFFFF, 16'd0});
    write_reg(REG_RELEASE, {16'd328, ONE_Q15, 16'd0, 16'hFFFF});
    write_reg(REG_HOLD, {40'hFF_FFFF_FFFF, 6'd1, 6'd60, 6'd63, 6'd0});
    send_levels({4{16'hFFFF}});
    send_levels({4{ONE_Q15}});
    send_levels({4{16'd32767}});
    send_levels({4{16'h8001}});
    send_levels({16'd32768, 16'd32736, 16'd1, 16'd16384});
    repeat (4) send_levels('0);
    drain();

    // disabled bands clear
    write_reg(REG_ENABLE, 64'h5);
    repeat (2) send_levels({4{16'h4000}});

    for (int p = 0; p < PHASES; p++) begin
      drain();
      load_settings(p);
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < WORDS_PER_PHASE; i++) send_levels(next_levels());
    end

    drain();
    repeat (200) @(posedge clk);

    $display("covered %0d level words over %0d random settings and the directed ones",
             sb.n_words, PHASES);
    $display("%0d result words checked, %0d of them with a band active",
             sb.n_checked, sb.n_active);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bef_pkg.sv
sv/bef_div.sv
sv/band_envelope_follower.sv
sv/bef_checker.sv
tb/band_envelope_follower_tb.sv
